// ===== sv/bcm_pkg.sv =====
// Shared types and constants of the backlight curve mapper.
// No dependencies; compile first.
package bcm_pkg;

	// Field widths and defaults
	localparam int LEVEL_BITS_DEF = 12;
	localparam int DRIVE_BITS     = 12;
	localparam int CFG_ADDR_BITS  = 3;
	localparam int CFG_DATA_BITS  = 12;

	// Configuration register indexes
	localparam logic [CFG_ADDR_BITS-1:0] REG_CURVE_SELECT   = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_HEADSET_MODE   = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_DRIVE_MIN      = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_DRIVE_MAX      = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_BRIGHTNESS_TOP = 3'd4;

	// Curve codes
	localparam logic [1:0] CURVE_LINEAR = 2'd0;
	localparam logic [1:0] CURVE_OLED4K = 2'd1;
	localparam logic [1:0] CURVE_FHD1   = 2'd2;
	localparam logic [1:0] CURVE_HBM    = 2'd3;

	// Headset mode codes
	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_ONE    = 2'd1;
	localparam logic [1:0] MODE_TWO    = 2'd2;
	localparam logic [1:0] MODE_LINEAR = 2'd3;

	// Reset values of the drive registers
	localparam logic [DRIVE_BITS-1:0] DRIVE_MAX_RST = 12'd4095;
	localparam logic [DRIVE_BITS-1:0] TOP_RST       = 12'd4095;

	typedef struct packed {
		logic [1:0]            curve_select;
		logic [1:0]            headset_mode;
		logic [DRIVE_BITS-1:0] drive_min;
		logic [DRIVE_BITS-1:0] drive_max;
		logic [DRIVE_BITS-1:0] brightness_top;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_x;
		logic setup;
		logic mul;
		logic fin;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fixed_path;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/bcm_req_if.sv =====
// Request channel of the backlight curve mapper: one brightness level.
// Depends on nothing.
interface bcm_req_if #(parameter int LEVEL_BITS = 12);
	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] level;

	modport source (output valid, output level, input ready);
	modport sink   (input valid, input level, output ready);
endinterface

// ===== sv/bcm_rsp_if.sv =====
// Result channel of the backlight curve mapper.
// Depends on nothing.
interface bcm_rsp_if;
	logic        valid;
	logic        ready;
	logic [11:0] drive_level;
	logic        hbm_change;
	logic        hbm_on;
	logic        divide_error;

	modport source (output valid, output drive_level, output hbm_change,
		output hbm_on, output divide_error, input ready);
	modport sink   (input valid, input drive_level, input hbm_change,
		input hbm_on, input divide_error, output ready);
endinterface

// ===== sv/bcm_cfg_if.sv =====
// Configuration write channel of the backlight curve mapper.
// Depends on nothing.
interface bcm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [11:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== sv/bcm_div.sv =====
// Restoring divider, two quotient bits per cycle, unsigned magnitudes.
// Used by bcm_dp; no package dependencies.
module bcm_div #(
	parameter int NUM_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [11:0]         den,
	output logic                busy,
	output logic [NUM_BITS-1:0] quo
);
	localparam int NWP   = ((NUM_BITS + 1) / 2) * 2;
	localparam int STEPS = NWP / 2;
	localparam int CW    = $clog2(STEPS);

	logic [NWP-1:0] acc_q;
	logic [11:0]    rem_q;
	logic [11:0]    den_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;

	logic [12:0] r1, r2;
	logic [13:0] t1, t2;
	logic        q1, q2;
	logic [11:0] rem1, rem2;

	// Two dependent restoring steps
	always_comb begin
		r1   = {rem_q, acc_q[NWP-1]};
		t1   = {1'b0, r1} - {2'b00, den_q};
		q1   = ~t1[13];
		rem1 = q1 ? t1[11:0] : r1[11:0];
		r2   = {rem1, acc_q[NWP-2]};
		t2   = {1'b0, r2} - {2'b00, den_q};
		q2   = ~t2[13];
		rem2 = q2 ? t2[11:0] : r2[11:0];
	end

	// Load, then shift dividend bits out and quotient bits in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= NWP'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			acc_q <= {acc_q[NWP-3:0], q1, q2};
			rem_q <= rem2;
		end
	end

	assign busy = busy_q;
	assign quo  = acc_q[NUM_BITS-1:0];

	// Counter stays inside the step range and the last step ends the run
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= CW'(STEPS - 1)))
		else $error("divider step counter out of range");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == CW'(STEPS - 1)) |=> !busy_q)
		else $error("divider still busy after last step");
endmodule

// ===== sv/bcm_dp.sv =====
// Datapath: segment selection, multiplier, shared divider, saturation,
// high-brightness tracking and result register. Uses bcm_pkg and bcm_div.
module bcm_dp #(
	parameter int LEVEL_BITS = bcm_pkg::LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bcm_pkg::cfg_t         cfg,
	input  logic [LEVEL_BITS-1:0] level,
	input  bcm_pkg::cmd_t         cmd,
	output bcm_pkg::sts_t         sts,
	bcm_rsp_if.source             rsp
);
	import bcm_pkg::*;

	localparam int NW = LEVEL_BITS + 12;

	typedef struct packed {
		logic        fixed;
		logic [11:0] fval;
		logic [11:0] x0;
		logic [11:0] y0;
		logic [11:0] x1;
		logic [11:0] y1;
	} seg_t;

	function automatic seg_t seg_f(input logic [11:0] x0, input logic [11:0] y0,
		input logic [11:0] x1, input logic [11:0] y1);
		seg_t s;
		s.fixed = 1'b0;
		s.fval  = '0;
		s.x0    = x0;
		s.y0    = y0;
		s.x1    = x1;
		s.y1    = y1;
		return s;
	endfunction

	function automatic seg_t fix_f(input logic [11:0] v);
		seg_t s;
		s       = '0;
		s.fixed = 1'b1;
		s.fval  = v;
		return s;
	endfunction

	logic [LEVEL_BITS-1:0] x_q;
	seg_t                  sel;
	logic [12:0]           dy, dd;
	logic [LEVEL_BITS-1:0] dx_q;
	logic [11:0]           dymag_q, dmag_q, y0_q, fval_q;
	logic                  neg_q, fixed_q, err_q;
	logic [NW-1:0]         prod, quo;
	logic                  div_busy;
	logic [11:0]           mx, top;

	logic                  q_hi;
	logic [12:0]           sum, diff;
	logic [11:0]           calc, drive_nxt;
	logic                  need, change_nxt, hbm_nxt;

	logic                  hbm_q, out_valid_q;
	logic [11:0]           drive_q;
	logic                  change_q, err_out_q;

	function automatic logic le(input logic [LEVEL_BITS-1:0] v, input logic [11:0] k);
		return v <= LEVEL_BITS'(k);
	endfunction

	assign mx  = cfg.drive_max;
	assign top = cfg.brightness_top;

	// Hold the accepted level
	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q <= level;
		end
	end

	// Pick the segment for this level
	always_comb begin
		sel = seg_f(12'd0, cfg.drive_min, top, mx);
		case (cfg.curve_select)
			CURVE_OLED4K: begin
				case (cfg.headset_mode)
					MODE_ONE: begin
						if (le(x_q, 12'd9))         sel = fix_f(12'd4);
						else if (le(x_q, 12'd287))  sel = seg_f(12'd9, 12'd4, 12'd287, 12'd326);
						else if (le(x_q, 12'd1024)) sel = seg_f(12'd287, 12'd613, 12'd1024, 12'd2047);
						else if (le(x_q, 12'd2662)) sel = seg_f(12'd1024, 12'd2048, 12'd2662, mx);
						else                        sel = fix_f(mx);
					end
					MODE_TWO: begin
						if (le(x_q, 12'd9))         sel = fix_f(12'd4);
						else if (le(x_q, 12'd226))  sel = seg_f(12'd9, 12'd4, 12'd226, 12'd279);
						else if (le(x_q, 12'd820))  sel = seg_f(12'd226, 12'd623, 12'd820, 12'd2047);
						else if (le(x_q, 12'd2253)) sel = seg_f(12'd820, 12'd2048, 12'd2253, mx);
						else                        sel = fix_f(mx);
					end
					MODE_OFF: begin
						if (le(x_q, 12'd9))         sel = fix_f(12'd4);
						else if (le(x_q, 12'd1720)) sel = seg_f(12'd9, 12'd4, 12'd1720, 12'd2047);
						else                        sel = seg_f(12'd1720, 12'd2048, top, mx);
					end
					default: ;
				endcase
			end
			CURVE_FHD1: begin
				case (cfg.headset_mode)
					MODE_ONE: begin
						if (le(x_q, 12'd9))         sel = fix_f(12'd4);
						else if (le(x_q, 12'd287))  sel = seg_f(12'd9, 12'd4, 12'd287, 12'd351);
						else if (le(x_q, 12'd1024)) sel = seg_f(12'd287, 12'd591, 12'd1024, 12'd2047);
						else if (le(x_q, 12'd2662)) sel = seg_f(12'd1024, 12'd2048, 12'd2662, mx);
						else                        sel = fix_f(mx);
					end
					MODE_TWO: begin
						if (le(x_q, 12'd217))       sel = seg_f(12'd0, 12'd4, 12'd217, 12'd279);
						else if (le(x_q, 12'd811))  sel = seg_f(12'd217, 12'd623, 12'd811, 12'd2047);
						else if (le(x_q, 12'd2248)) sel = seg_f(12'd811, 12'd2048, 12'd2248, mx);
						else                        sel = fix_f(mx);
					end
					MODE_OFF: begin
						if (le(x_q, 12'd9))         sel = fix_f(12'd4);
						else if (le(x_q, 12'd1638)) sel = seg_f(12'd9, 12'd4, 12'd1638, 12'd2047);
						else if (le(x_q, 12'd2662)) sel = seg_f(12'd1638, 12'd2048, 12'd2662, 12'd3072);
						else                        sel = seg_f(12'd2662, 12'd3073, top, mx);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Signed differences of the segment
	assign dy = {1'b0, sel.y1} - {1'b0, sel.y0};
	assign dd = {1'b0, sel.x1} - {1'b0, sel.x0};

	// Register segment operands as sign and magnitude
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			dx_q    <= x_q - LEVEL_BITS'(sel.x0);
			dymag_q <= dy[12] ? 12'(-dy) : dy[11:0];
			dmag_q  <= dd[12] ? 12'(-dd) : dd[11:0];
			neg_q   <= dy[12] ^ dd[12];
			y0_q    <= sel.y0;
			fixed_q <= sel.fixed | (dd == '0);
			err_q   <= ~sel.fixed & (dd == '0);
			fval_q  <= sel.fixed ? sel.fval : mx;
		end
	end

	// Product feeds the divider, which registers it
	assign prod = dx_q * dymag_q;

	bcm_div #(.NUM_BITS(NW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul & ~fixed_q),
		.num   (prod),
		.den   (dmag_q),
		.busy  (div_busy),
		.quo   (quo)
	);

	// Add or subtract the quotient and saturate to 0..4095
	always_comb begin
		q_hi = |quo[NW-1:12];
		sum  = {1'b0, y0_q} + {1'b0, quo[11:0]};
		diff = {1'b0, y0_q} - {1'b0, quo[11:0]};
		if (neg_q) begin
			calc = (q_hi || diff[12]) ? 12'd0 : diff[11:0];
		end else begin
			calc = (q_hi || sum[12]) ? 12'd4095 : sum[11:0];
		end
		drive_nxt = fixed_q ? fval_q : calc;
		need      = drive_nxt[11];
		if (cfg.curve_select == CURVE_HBM) begin
			change_nxt = need ^ hbm_q;
			hbm_nxt    = need;
		end else begin
			change_nxt = 1'b0;
			hbm_nxt    = hbm_q;
		end
	end

	// Result register and mode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hbm_q       <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
			hbm_q       <= hbm_nxt;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			drive_q   <= drive_nxt;
			change_q  <= change_nxt;
			err_out_q <= err_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.drive_level  = drive_q;
	assign rsp.hbm_change   = change_q;
	assign rsp.hbm_on       = hbm_q;
	assign rsp.divide_error = err_out_q;

	assign sts.fixed_path = fixed_q;
	assign sts.div_busy   = div_busy;
	assign sts.out_free   = ~out_valid_q | rsp.ready;

	// A mode switch always lands on the side the result asks for
	a_hbm_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.hbm_change) |-> (rsp.hbm_on == rsp.drive_level[11]))
		else $error("high-brightness state disagrees with result");
endmodule

// ===== sv/bcm_ctrl.sv =====
// Controller state machine: sequences setup, multiply, divide and result load.
// Uses bcm_pkg.
module bcm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bcm_pkg::sts_t sts,
	output bcm_pkg::cmd_t cmd
);
	import bcm_pkg::*;

	state_t state_q, state_nxt;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:  if (req_valid) state_nxt = S_SETUP;
			S_SETUP: state_nxt = S_MUL;
			S_MUL:   state_nxt = sts.fixed_path ? S_FIN : S_DIV;
			S_DIV:   if (!sts.div_busy) state_nxt = S_FIN;
			S_FIN:   if (sts.out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.load_x = req_valid;
			end
			S_SETUP: cmd.setup = 1'b1;
			S_MUL:   cmd.mul   = 1'b1;
			S_FIN:   cmd.fin   = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.out_free)
		else $error("result loaded over a pending one");
	// A divide run starting leaves the divider busy in the next cycle
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul && !sts.fixed_path) |=> (sts.div_busy && state_q == S_DIV))
		else $error("divider did not start");
endmodule

// ===== sv/backlight_curve_mapper_core.sv =====
// Top level of the backlight curve mapper: configuration registers,
// controller and datapath. Uses bcm_pkg, the bcm_*_if interfaces, bcm_ctrl, bcm_dp.
//
//  channel | direction | payload                                     | handshake
//  req     | in        | level                                       | valid/ready
//  rsp     | out       | drive_level, hbm_change, hbm_on, divide_error | valid/ready
//  cfg     | in        | addr (register index), data                 | valid/ready
//
// An item on a sloped segment passes through setup, multiply, the two-bit-per-cycle
// divider and the result load; a flat segment or zero divisor skips the divider. The
// next request is taken in the cycle after the result is loaded, even while that
// result is not yet taken.
// arst_n clears the controller, the result valid and the high-brightness state
// and sets the registers to their defaults. cfg is always ready.
module backlight_curve_mapper_core #(
	parameter int LEVEL_BITS = bcm_pkg::LEVEL_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bcm_req_if.sink    req,
	bcm_rsp_if.source  rsp,
	bcm_cfg_if.sink    cfg
);
	import bcm_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// Register writes; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.curve_select   <= CURVE_LINEAR;
			cfg_q.headset_mode   <= MODE_OFF;
			cfg_q.drive_min      <= '0;
			cfg_q.drive_max      <= DRIVE_MAX_RST;
			cfg_q.brightness_top <= TOP_RST;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_CURVE_SELECT:   cfg_q.curve_select   <= cfg.data[1:0];
				REG_HEADSET_MODE:   cfg_q.headset_mode   <= cfg.data[1:0];
				REG_DRIVE_MIN:      cfg_q.drive_min      <= cfg.data;
				REG_DRIVE_MAX:      cfg_q.drive_max      <= cfg.data;
				REG_BRIGHTNESS_TOP: cfg_q.brightness_top <= cfg.data;
				default: ;
			endcase
		end
	end

	bcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bcm_dp #(.LEVEL_BITS(LEVEL_BITS)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.level (req.level),
		.cmd   (cmd),
		.sts   (sts),
		.rsp   (rsp)
	);
endmodule

// ===== sim/tb_backlight_curve_mapper_core.sv =====
`timescale 1ns / 100ps
// Self-checking bench for backlight_curve_mapper_core: directed rows, then random levels
// under changing curve settings and handshake pressure, checked against a local curve model.
// Depends on bcm_pkg, the bcm_*_if interfaces and the core with its submodules.
module tb_backlight_curve_mapper_core;
	import bcm_pkg::*;

	localparam int LVL_W        = LEVEL_BITS_DEF;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 24;
	localparam int RAND_PHASES  = 4;
	localparam int SETS_PER_PHASE = 6;
	localparam int LEVELS_PER_SET = 60;
	localparam int REPORT_CAP   = 40;
	localparam longint DRIVE_CEIL = 4095;
	localparam logic [DRIVE_BITS-1:0] HBM_KNEE = 12'h800;
	// First index past the register list; writes there must be ignored
	localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_FIRST = 3'd5;

	typedef struct packed {
		logic [DRIVE_BITS-1:0] drive;
		logic                  change;
		logic                  on;
		logic                  div_err;
	} drive_result_t;

	typedef struct {
		bit                       is_cfg;
		logic [CFG_ADDR_BITS-1:0] idx;
		logic [11:0]              value;
		bit                       typed;
		drive_result_t            want;
	} plan_step_t;

	logic clk;
	logic arst_n;

	bcm_req_if #(.LEVEL_BITS(LVL_W)) req_ch();
	bcm_rsp_if rsp_ch();
	bcm_cfg_if cfg_ch();

	backlight_curve_mapper_core #(.LEVEL_BITS(LVL_W)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the register file and the high-brightness state
	logic [1:0]            cur_curve;
	logic [1:0]            cur_mode;
	logic [DRIVE_BITS-1:0] cur_min;
	logic [DRIVE_BITS-1:0] cur_max;
	logic [DRIVE_BITS-1:0] cur_top;
	logic                  hbm_state;
	bit                    zero_div;

	drive_result_t drive_pending[$];
	plan_step_t    plan[$];

	int idle_pct;
	int stall_pct;
	int errors;
	int cycles;
	int levels_sent;
	int results_seen;
	int reg_writes;
	int hbm_switches;
	int div_faults;

	// Clock: 20 ns period
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				drive_pending.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stall the result channel at random
	always @(negedge clk)
		rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);

	// ---------------------------------------------------------------- curve model

	function automatic longint ramp(input longint x, input longint x0, input longint y0,
		input longint x1, input longint y1);
		longint span;
		span = x1 - x0;
		if (span == 0) begin
			zero_div = 1'b1;
			return longint'(cur_max);
		end
		return y0 + ((x - x0) * (y1 - y0)) / span;
	endfunction

	function automatic longint line_map(input longint x);
		return ramp(x, 0, longint'(cur_min), longint'(cur_top), longint'(cur_max));
	endfunction

	function automatic longint oled4k_curve(input longint x);
		longint mx;
		longint top;
		mx = longint'(cur_max);
		top = longint'(cur_top);
		case (cur_mode)
			MODE_ONE: begin
				if (x <= 9) return 4;
				if (x <= 287) return ramp(x, 9, 4, 287, 326);
				if (x <= 1024) return ramp(x, 287, 613, 1024, 2047);
				if (x <= 2662) return ramp(x, 1024, 2048, 2662, mx);
				return mx;
			end
			MODE_TWO: begin
				if (x <= 9) return 4;
				if (x <= 226) return ramp(x, 9, 4, 226, 279);
				if (x <= 820) return ramp(x, 226, 623, 820, 2047);
				if (x <= 2253) return ramp(x, 820, 2048, 2253, mx);
				return mx;
			end
			MODE_OFF: begin
				if (x <= 9) return 4;
				if (x <= 1720) return ramp(x, 9, 4, 1720, 2047);
				return ramp(x, 1720, 2048, top, mx);
			end
			default: return line_map(x);
		endcase
	endfunction

	function automatic longint fhd1_curve(input longint x);
		longint mx;
		longint top;
		mx = longint'(cur_max);
		top = longint'(cur_top);
		case (cur_mode)
			MODE_ONE: begin
				if (x <= 9) return 4;
				if (x <= 287) return ramp(x, 9, 4, 287, 351);
				if (x <= 1024) return ramp(x, 287, 591, 1024, 2047);
				if (x <= 2662) return ramp(x, 1024, 2048, 2662, mx);
				return mx;
			end
			MODE_TWO: begin
				if (x <= 217) return ramp(x, 0, 4, 217, 279);
				if (x <= 811) return ramp(x, 217, 623, 811, 2047);
				if (x <= 2248) return ramp(x, 811, 2048, 2248, mx);
				return mx;
			end
			MODE_OFF: begin
				if (x <= 9) return 4;
				if (x <= 1638) return ramp(x, 9, 4, 1638, 2047);
				if (x <= 2662) return ramp(x, 1638, 2048, 2662, 3072);
				return ramp(x, 2662, 3073, top, mx);
			end
			default: return line_map(x);
		endcase
	endfunction

	// Map one level to its drive result and advance the high-brightness state
	function automatic drive_result_t map_level(input logic [LVL_W-1:0] lvl);
		longint        x;
		longint        y;
		logic          need;
		drive_result_t r;
		zero_div = 1'b0;
		x = longint'(lvl);
		case (cur_curve)
			CURVE_OLED4K: y = oled4k_curve(x);
			CURVE_FHD1:   y = fhd1_curve(x);
			default:      y = line_map(x);
		endcase
		if (y < 0) y = 0;
		if (y > DRIVE_CEIL) y = DRIVE_CEIL;
		r.drive = y[DRIVE_BITS-1:0];
		r.change = 1'b0;
		if (cur_curve == CURVE_HBM) begin
			need = (r.drive >= HBM_KNEE);
			if (need != hbm_state) begin
				r.change = 1'b1;
				hbm_state = need;
			end
		end
		r.on = hbm_state;
		r.div_err = zero_div;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic int knee_level();
		case ($urandom_range(0, 11))
			0:  return 9;
			1:  return 217;
			2:  return 226;
			3:  return 287;
			4:  return 811;
			5:  return 820;
			6:  return 1024;
			7:  return 1638;
			8:  return 1720;
			9:  return 2248;
			10: return 2253;
			default: return 2662;
		endcase
	endfunction

	function automatic logic [LVL_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return LVL_W'(knee_level() + $urandom_range(0, 2) - 1);
			default: return LVL_W'($urandom);
		endcase
	endfunction

	function automatic logic [11:0] pick_drive();
		case ($urandom_range(0, 7))
			0:       return 12'd0;
			1:       return 12'd4095;
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic logic [11:0] pick_top();
		case ($urandom_range(0, 9))
			0:       return 12'd0;
			1:       return 12'd4095;
			2, 3:    return 12'(knee_level());
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic plan_step_t cfg_step(input logic [CFG_ADDR_BITS-1:0] idx,
		input logic [11:0] val);
		plan_step_t s;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.value = val;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic plan_step_t lvl_step(input logic [11:0] lvl);
		plan_step_t s;
		s.is_cfg = 1'b0;
		s.idx = '0;
		s.value = lvl;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic plan_step_t typed_step(input logic [11:0] lvl,
		input logic [11:0] drive, input logic chg, input logic on, input logic err);
		plan_step_t s;
		s = lvl_step(lvl);
		s.typed = 1'b1;
		s.want = {drive, chg, on, err};
		return s;
	endfunction

	// Offer one level; called at a falling edge, returns at a falling edge with valid held
	task automatic push_level(input logic [LVL_W-1:0] lvl, input bit typed,
		input drive_result_t want);
		drive_result_t r;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid = 1'b0;
			req_ch.level = LVL_W'($urandom);
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.level = lvl;
		do @(posedge clk); while (!req_ch.ready);
		r = map_level(lvl);
		if (typed)
			r = want;
		if (r.change) hbm_switches++;
		if (r.div_err) div_faults++;
		drive_pending.push_back(r);
		levels_sent++;
		@(negedge clk);
	endtask

	// Drop the request and hold until every result is back
	task automatic wait_drained();
		req_ch.valid = 1'b0;
		while (drive_pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input logic [11:0] val);
		cfg_ch.valid = 1'b1;
		cfg_ch.addr = idx;
		cfg_ch.data = val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_CURVE_SELECT:   cur_curve = val[1:0];
			REG_HEADSET_MODE:   cur_mode = val[1:0];
			REG_DRIVE_MIN:      cur_min = val;
			REG_DRIVE_MAX:      cur_max = val;
			REG_BRIGHTNESS_TOP: cur_top = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = '0;
		cfg_ch.data = '0;
	endtask

	// ---------------------------------------------------------------- result check

	task automatic note_mismatch(input string field, input logic [11:0] want,
		input logic [11:0] got);
		errors++;
		if (errors <= REPORT_CAP)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		drive_result_t got;
		drive_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = {rsp_ch.drive_level, rsp_ch.hbm_change, rsp_ch.hbm_on, rsp_ch.divide_error};
			results_seen++;
			if (drive_pending.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: result with nothing outstanding, expected none, got %0d",
						$time, got.drive);
			end else begin
				want = drive_pending.pop_front();
				if (got.drive !== want.drive)
					note_mismatch("drive_level", want.drive, got.drive);
				if (got.change !== want.change)
					note_mismatch("hbm_change", want.change, got.change);
				if (got.on !== want.on)
					note_mismatch("hbm_on", want.on, got.on);
				if (got.div_err !== want.div_err)
					note_mismatch("divide_error", want.div_err, got.div_err);
			end
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.level = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = '0;
		cfg_ch.data = '0;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		cycles = 0;
		levels_sent = 0;
		results_seen = 0;
		reg_writes = 0;
		hbm_switches = 0;
		div_faults = 0;
		cur_curve = CURVE_LINEAR;
		cur_mode = MODE_OFF;
		cur_min = '0;
		cur_max = DRIVE_MAX_RST;
		cur_top = TOP_RST;
		hbm_state = 1'b0;

		// Directed rows: reset defaults, zero divisors, tracking, saturation, every curve
		plan.push_back(typed_step(12'd0, 12'd0, 1'b0, 1'b0, 1'b0));
		plan.push_back(typed_step(12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0));
		plan.push_back(typed_step(12'd2048, 12'd2048, 1'b0, 1'b0, 1'b0));
		plan.push_back(cfg_step(REG_BRIGHTNESS_TOP, 12'd0));
		plan.push_back(typed_step(12'd5, 12'd4095, 1'b0, 1'b0, 1'b1));
		plan.push_back(cfg_step(REG_DRIVE_MAX, 12'd100));
		plan.push_back(typed_step(12'd0, 12'd100, 1'b0, 1'b0, 1'b1));
		plan.push_back(cfg_step(REG_DRIVE_MAX, 12'd4095));
		plan.push_back(cfg_step(REG_BRIGHTNESS_TOP, 12'd4095));
		plan.push_back(cfg_step(REG_CURVE_SELECT, {10'd0, CURVE_HBM}));
		plan.push_back(typed_step(12'd4095, 12'd4095, 1'b1, 1'b1, 1'b0));
		plan.push_back(typed_step(12'd4095, 12'd4095, 1'b0, 1'b1, 1'b0));
		plan.push_back(typed_step(12'd0, 12'd0, 1'b1, 1'b0, 1'b0));
		plan.push_back(typed_step(12'd2048, 12'd2048, 1'b1, 1'b1, 1'b0));
		plan.push_back(typed_step(12'd2047, 12'd2047, 1'b1, 1'b0, 1'b0));
		// Zero divisor under tracking still switches on the saturated result
		plan.push_back(cfg_step(REG_BRIGHTNESS_TOP, 12'd0));
		plan.push_back(typed_step(12'd1, 12'd4095, 1'b1, 1'b1, 1'b1));
		plan.push_back(cfg_step(REG_CURVE_SELECT, {10'h3FF, CURVE_LINEAR}));
		plan.push_back(typed_step(12'd7, 12'd4095, 1'b0, 1'b1, 1'b1));
		// Saturate low, then high
		plan.push_back(cfg_step(REG_DRIVE_MIN, 12'd4095));
		plan.push_back(cfg_step(REG_DRIVE_MAX, 12'd0));
		plan.push_back(cfg_step(REG_BRIGHTNESS_TOP, 12'd10));
		plan.push_back(typed_step(12'd4095, 12'd0, 1'b0, 1'b1, 1'b0));
		plan.push_back(cfg_step(REG_DRIVE_MIN, 12'd0));
		plan.push_back(cfg_step(REG_DRIVE_MAX, 12'd4095));
		plan.push_back(cfg_step(REG_BRIGHTNESS_TOP, 12'd1));
		plan.push_back(typed_step(12'd4095, 12'd4095, 1'b0, 1'b1, 1'b0));
		// 4K OLED curve in every headset mode
		plan.push_back(cfg_step(REG_BRIGHTNESS_TOP, 12'd4095));
		plan.push_back(cfg_step(REG_CURVE_SELECT, {10'd0, CURVE_OLED4K}));
		plan.push_back(typed_step(12'd9, 12'd4, 1'b0, 1'b1, 1'b0));
		plan.push_back(lvl_step(12'd1000));
		plan.push_back(lvl_step(12'd4095));
		plan.push_back(cfg_step(REG_HEADSET_MODE, {10'd0, MODE_ONE}));
		plan.push_back(typed_step(12'd4095, 12'd4095, 1'b0, 1'b1, 1'b0));
		plan.push_back(lvl_step(12'd500));
		plan.push_back(cfg_step(REG_HEADSET_MODE, {10'h155, MODE_TWO}));
		plan.push_back(lvl_step(12'd2000));
		plan.push_back(cfg_step(REG_HEADSET_MODE, {10'd0, MODE_LINEAR}));
		plan.push_back(lvl_step(12'd3000));
		// Top equal to the breakpoint gives a zero divisor on the top segment
		plan.push_back(cfg_step(REG_BRIGHTNESS_TOP, 12'd1720));
		plan.push_back(cfg_step(REG_HEADSET_MODE, {10'd0, MODE_OFF}));
		plan.push_back(typed_step(12'd1721, 12'd4095, 1'b0, 1'b1, 1'b1));
		// FHD curve with top below the breakpoint: negative divisor
		plan.push_back(cfg_step(REG_CURVE_SELECT, {10'd0, CURVE_FHD1}));
		plan.push_back(cfg_step(REG_BRIGHTNESS_TOP, 12'd100));
		plan.push_back(lvl_step(12'd4000));
		plan.push_back(cfg_step(REG_HEADSET_MODE, {10'd0, MODE_TWO}));
		plan.push_back(typed_step(12'd0, 12'd4, 1'b0, 1'b1, 1'b0));
		// Writes past the register list must leave everything as it was
		plan.push_back(cfg_step(REG_SPARE_FIRST, 12'hFFF));
		plan.push_back(cfg_step(REG_SPARE_FIRST + 3'd2, 12'h000));
		plan.push_back(lvl_step(12'd100));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed rows
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_drained();
				write_reg(plan[i].idx, plan[i].value);
			end else begin
				push_level(LVL_W'(plan[i].value), plan[i].typed, plan[i].want);
			end
		end

		// Random part: one idling mix per phase, several register settings per phase
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 54; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 54; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			for (int set = 0; set < SETS_PER_PHASE; set++) begin
				wait_drained();
				write_reg(REG_CURVE_SELECT, {10'($urandom), 2'($urandom)});
				write_reg(REG_HEADSET_MODE, {10'($urandom), 2'($urandom)});
				write_reg(REG_DRIVE_MIN, pick_drive());
				write_reg(REG_DRIVE_MAX, pick_drive());
				write_reg(REG_BRIGHTNESS_TOP, pick_top());
				if ($urandom_range(0, 2) == 0)
					write_reg(REG_SPARE_FIRST + 3'($urandom_range(0, 2)), 12'($urandom));
				for (int n = 0; n < LEVELS_PER_SET; n++)
					push_level(pick_level(), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d levels and %0d results over %0d register writes", levels_sent,
			results_seen, reg_writes);
		$display("high-brightness switches %0d, zero-divisor results %0d, mismatches %0d",
			hbm_switches, div_faults, errors);
		if (errors == 0 && drive_pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
